// ===== hw/rtl/jtcm_pkg.sv =====
package jtcm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE / 2;
  localparam int OUT_MAX   = 32767;
  localparam int OUT_MIN   = -32768;

  localparam int COORD_W  = 16;
  localparam int MUL_IN_W = COORD_W + 2;      // 3*u fits in two more bits
  localparam int PROD_W   = 2 * MUL_IN_W;
  localparam int SQ_W     = 24;               // squares of the scaled point and w
  localparam int SQ2_W    = 2 * SQ_W;
  localparam int Q_W      = 32;               // q components and |w|^2
  localparam int QP_W     = Q_W + SQ_W;
  localparam int NUM_W    = 40;               // numerators of the quotient
  localparam int DEN_W    = 32;               // 3*|w|^2
  localparam int MAG_W    = NUM_W - 1;
  localparam int DVD_W    = MAG_W + FRAC_BITS;
  localparam int QBITS    = 17;               // any larger quotient clips the output
  localparam int REM_W    = DEN_W + QBITS;

  localparam int FRONT_STAGES = 6;
  localparam int DIV_STAGES   = QBITS + 2;
  localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + 1;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_P0   = 3'd1,
    REG_P1   = 3'd2,
    REG_P2   = 3'd3,
    REG_P3   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] u_coord;
    logic signed [COORD_W-1:0] v_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] tex_x;
    logic signed [COORD_W-1:0] tex_y;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic                      rational_mode;
    logic signed [COORD_W-1:0] param_p0;
    logic signed [COORD_W-1:0] param_p1;
    logic signed [COORD_W-1:0] param_p2;
    logic signed [COORD_W-1:0] param_p3;
  } cfg_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [QBITS-1:0] quot;
  } div_out_t;

endpackage

// ===== hw/rtl/julia_texture_coordinate_map_top.sv =====
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_data  (u_coord, v_coord)
// out      output     out_valid / out_ready out_data (tex_x, tex_y, saturated)
// cfg      input      APB psel / penable    paddr, pwdata, prdata
//
// One point enters per cycle while the output is not stalled.
// The pipeline is built from six arithmetic stages, two divider setup stages, one
// restoring-divider stage per quotient bit (17) and the output register.
// Reset clears the valid bits and the configuration registers; payload registers are not reset.
// A stalled output freezes the whole pipeline, and in_ready drops in the same cycle.
module julia_texture_coordinate_map_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  jtcm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jtcm_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int DEPTH  = jtcm_pkg::PIPE_DEPTH;
  localparam int DSTG   = jtcm_pkg::DIV_STAGES;

  jtcm_pkg::cfg_t cfg;
  logic           en;
  logic [DEPTH-1:0] vld;

  logic signed [jtcm_pkg::NUM_W-1:0] nx, ny;
  logic        [jtcm_pkg::DEN_W-1:0] dsr;
  logic signed [jtcm_pkg::SQ_W-1:0]  quad_x, quad_y;
  logic signed [jtcm_pkg::SQ_W-1:0]  qdx [DSTG];
  logic signed [jtcm_pkg::SQ_W-1:0]  qdy [DSTG];
  jtcm_pkg::div_out_t                div_x, div_y;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        jtcm_pkg::REG_MODE: cfg.rational_mode <= pwdata[0];
        jtcm_pkg::REG_P0:   cfg.param_p0      <= pwdata[15:0];
        jtcm_pkg::REG_P1:   cfg.param_p1      <= pwdata[15:0];
        jtcm_pkg::REG_P2:   cfg.param_p2      <= pwdata[15:0];
        jtcm_pkg::REG_P3:   cfg.param_p3      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      jtcm_pkg::REG_MODE: prdata = {31'b0, cfg.rational_mode};
      jtcm_pkg::REG_P0:   prdata = {16'b0, cfg.param_p0};
      jtcm_pkg::REG_P1:   prdata = {16'b0, cfg.param_p1};
      jtcm_pkg::REG_P2:   prdata = {16'b0, cfg.param_p2};
      jtcm_pkg::REG_P3:   prdata = {16'b0, cfg.param_p3};
      default:            prdata = '0;
    endcase
  end

  assign out_valid = vld[DEPTH-1];
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  jtcm_front u_front (
    .clk    (clk),
    .en     (en),
    .cfg    (cfg),
    .item   (in_data),
    .nx     (nx),
    .ny     (ny),
    .dsr    (dsr),
    .quad_x (quad_x),
    .quad_y (quad_y)
  );

  jtcm_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (nx),
    .dsr (dsr),
    .res (div_x)
  );

  jtcm_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (ny),
    .dsr (dsr),
    .res (div_y)
  );

  // The quadratic results wait beside the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      qdx[0] <= quad_x;
      qdy[0] <= quad_y;
      for (int i = 1; i < DSTG; i++) begin
        qdx[i] <= qdx[i-1];
        qdy[i] <= qdy[i-1];
      end
    end
  end

  jtcm_out u_out (
    .clk           (clk),
    .en            (en),
    .rational_mode (cfg.rational_mode),
    .div_x         (div_x),
    .div_y         (div_y),
    .quad_x        (qdx[DSTG-1]),
    .quad_y        (qdy[DSTG-1]),
    .item          (out_data)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pipeline not empty after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("valid bits moved during a stall");

  a_enter: assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> vld[0])
    else $error("accepted transfer did not enter the pipeline");

endmodule

// ===== hw/rtl/jtcm_front.sv =====
module jtcm_front (
  input  logic                                 clk,
  input  logic                                 en,
  input  jtcm_pkg::cfg_t                       cfg,
  input  jtcm_pkg::in_item_t                   item,
  output logic signed [jtcm_pkg::NUM_W-1:0]    nx,
  output logic signed [jtcm_pkg::NUM_W-1:0]    ny,
  output logic        [jtcm_pkg::DEN_W-1:0]    dsr,
  output logic signed [jtcm_pkg::SQ_W-1:0]     quad_x,
  output logic signed [jtcm_pkg::SQ_W-1:0]     quad_y
);

  localparam int F = jtcm_pkg::FRAC_BITS;

  logic signed [jtcm_pkg::MUL_IN_W-1:0] ma, mb;
  logic signed [jtcm_pkg::PROD_W-1:0]   s1_pa, s1_pb, s1_pab;

  logic signed [jtcm_pkg::SQ_W-1:0] sa, sb, ab, c1, c2;
  logic signed [jtcm_pkg::SQ_W-1:0] s2_sa, s2_sb, s2_ab, s2_dif, s2_wr, s2_wi, s2_qx, s2_qy;

  logic signed [jtcm_pkg::SQ2_W-1:0] s3_t1, s3_t2, s3_t3, s3_t4, s3_w1, s3_w2;
  logic signed [jtcm_pkg::SQ_W-1:0]  s3_wr, s3_wi, s3_qx, s3_qy;

  logic signed [jtcm_pkg::Q_W-1:0]  t2s;
  logic signed [jtcm_pkg::Q_W-1:0]  s4_qr, s4_qi, s4_den;
  logic signed [jtcm_pkg::SQ_W-1:0] s4_wr, s4_wi, s4_qx, s4_qy;

  logic signed [jtcm_pkg::QP_W-1:0] s5_m1, s5_m2, s5_m3, s5_m4;
  logic signed [jtcm_pkg::Q_W-1:0]  s5_den;
  logic signed [jtcm_pkg::SQ_W-1:0] s5_qx, s5_qy;

  // In rational mode the point is scaled by 3 before squaring.
  always_comb begin
    if (cfg.rational_mode) begin
      ma = (jtcm_pkg::MUL_IN_W'(item.u_coord) <<< 1) + jtcm_pkg::MUL_IN_W'(item.u_coord);
      mb = (jtcm_pkg::MUL_IN_W'(item.v_coord) <<< 1) + jtcm_pkg::MUL_IN_W'(item.v_coord);
    end else begin
      ma = jtcm_pkg::MUL_IN_W'(item.u_coord);
      mb = jtcm_pkg::MUL_IN_W'(item.v_coord);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pa  <= ma * ma;
      s1_pb  <= mb * mb;
      s1_pab <= ma * mb;
    end
  end

  always_comb begin
    sa = jtcm_pkg::SQ_W'(s1_pa >>> F);
    sb = jtcm_pkg::SQ_W'(s1_pb >>> F);
    ab = jtcm_pkg::SQ_W'(s1_pab >>> F);
    c1 = ((jtcm_pkg::SQ_W'(cfg.param_p0) - jtcm_pkg::SQ_W'(jtcm_pkg::HALF)) >>> 2)
         + jtcm_pkg::SQ_W'(jtcm_pkg::HALF);
    c2 = (jtcm_pkg::SQ_W'(cfg.param_p1) >>> 2) + jtcm_pkg::SQ_W'(jtcm_pkg::HALF);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sa  <= sa;
      s2_sb  <= sb;
      s2_ab  <= ab;
      s2_dif <= sa - sb;
      s2_wr  <= sa - sb + (jtcm_pkg::SQ_W'(cfg.param_p2) <<< 1);
      s2_wi  <= (ab <<< 1) + (jtcm_pkg::SQ_W'(cfg.param_p3) <<< 1);
      s2_qx  <= sa - sb + c1;
      // The quadratic map rounds 2*u*v once, so shift the raw product by one less.
      s2_qy  <= jtcm_pkg::SQ_W'(s1_pab >>> (F - 1)) + c2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_t1 <= s2_sa * s2_sa;
      s3_t2 <= s2_sa * s2_sb;
      s3_t3 <= s2_sb * s2_sb;
      s3_t4 <= s2_ab * s2_dif;
      s3_w1 <= s2_wr * s2_wr;
      s3_w2 <= s2_wi * s2_wi;
      s3_wr <= s2_wr;
      s3_wi <= s2_wi;
      s3_qx <= s2_qx;
      s3_qy <= s2_qy;
    end
  end

  assign t2s = jtcm_pkg::Q_W'(s3_t2 >>> F);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_qr  <= jtcm_pkg::Q_W'(s3_t1 >>> F) - ((t2s <<< 2) + (t2s <<< 1))
                + jtcm_pkg::Q_W'(s3_t3 >>> F) + jtcm_pkg::Q_W'(cfg.param_p0);
      s4_qi  <= (jtcm_pkg::Q_W'(s3_t4 >>> F) <<< 2) + jtcm_pkg::Q_W'(cfg.param_p1);
      s4_den <= jtcm_pkg::Q_W'(s3_w1 >>> F) + jtcm_pkg::Q_W'(s3_w2 >>> F);
      s4_wr  <= s3_wr;
      s4_wi  <= s3_wi;
      s4_qx  <= s3_qx;
      s4_qy  <= s3_qy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_m1  <= s4_qr * s4_wr;
      s5_m2  <= s4_qi * s4_wi;
      s5_m3  <= s4_qr * s4_wi;
      s5_m4  <= s4_wr * s4_qi;
      s5_den <= s4_den;
      s5_qx  <= s4_qx;
      s5_qy  <= s4_qy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx     <= jtcm_pkg::NUM_W'(s5_m1 >>> F) + jtcm_pkg::NUM_W'(s5_m2 >>> F);
      ny     <= jtcm_pkg::NUM_W'(s5_m3 >>> F) + jtcm_pkg::NUM_W'(s5_m4 >>> F);
      dsr    <= jtcm_pkg::DEN_W'((s5_den <<< 1) + s5_den);
      quad_x <= s5_qx;
      quad_y <= s5_qy;
    end
  end

endmodule

// ===== hw/rtl/jtcm_div.sv =====
module jtcm_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [jtcm_pkg::NUM_W-1:0] num,
  input  logic        [jtcm_pkg::DEN_W-1:0] dsr,
  output jtcm_pkg::div_out_t                res
);

  localparam int QB = jtcm_pkg::QBITS;

  logic                          a_neg;
  logic [jtcm_pkg::MAG_W-1:0]    a_mag;
  logic [jtcm_pkg::DEN_W-1:0]    a_dsr;
  logic [jtcm_pkg::DVD_W-1:0]    dividend;

  logic [jtcm_pkg::REM_W-1:0]    rem_s [QB+1];
  logic [jtcm_pkg::DEN_W-1:0]    dsr_s [QB+1];
  logic [QB-1:0]                 quot_s [QB+1];
  logic                          neg_s [QB+1];
  logic                          ovf_s [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      a_neg <= num[jtcm_pkg::NUM_W-1];
      a_mag <= num[jtcm_pkg::NUM_W-1] ? jtcm_pkg::MAG_W'(-num) : jtcm_pkg::MAG_W'(num);
      a_dsr <= dsr;
    end
  end

  assign dividend = {a_mag, {jtcm_pkg::FRAC_BITS{1'b0}}};

  // A quotient of 2^QBITS or more, or a zero divisor, always sets ovf, which clips the rational-mode output.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_s[0]  <= dividend >= (jtcm_pkg::DVD_W'(a_dsr) << QB);
      rem_s[0]  <= jtcm_pkg::REM_W'(dividend);
      dsr_s[0]  <= a_dsr;
      quot_s[0] <= '0;
      neg_s[0]  <= a_neg;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = QB - 1 - j;
    logic [jtcm_pkg::REM_W-1:0] trial;
    logic                       ge;

    assign trial = jtcm_pkg::REM_W'(dsr_s[j]) << K;
    assign ge    = rem_s[j] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j+1]  <= ge ? rem_s[j] - trial : rem_s[j];
        quot_s[j+1] <= {quot_s[j][QB-2:0], ge};
        dsr_s[j+1]  <= dsr_s[j];
        neg_s[j+1]  <= neg_s[j];
        ovf_s[j+1]  <= ovf_s[j];
      end
    end
  end

  assign res.neg  = neg_s[QB];
  assign res.ovf  = ovf_s[QB];
  assign res.quot = quot_s[QB];

endmodule

// ===== hw/rtl/jtcm_out.sv =====
module jtcm_out (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              rational_mode,
  input  jtcm_pkg::div_out_t                div_x,
  input  jtcm_pkg::div_out_t                div_y,
  input  logic signed [jtcm_pkg::SQ_W-1:0]  quad_x,
  input  logic signed [jtcm_pkg::SQ_W-1:0]  quad_y,
  output jtcm_pkg::out_item_t               item
);

  localparam int W = jtcm_pkg::COORD_W;

  logic [W:0] cx, cy;

  function automatic logic [W:0] clamp16(input logic signed [jtcm_pkg::SQ_W-1:0] x);
    logic [W:0] r;
    if (x > jtcm_pkg::SQ_W'(jtcm_pkg::OUT_MAX)) begin
      r = {1'b1, W'(jtcm_pkg::OUT_MAX)};
    end else if (x < jtcm_pkg::SQ_W'(jtcm_pkg::OUT_MIN)) begin
      r = {1'b1, W'(jtcm_pkg::OUT_MIN)};
    end else begin
      r = {1'b0, W'(x)};
    end
    return r;
  endfunction

  // Signed quotient, plus one, halved with rounding toward minus infinity.
  function automatic logic [W:0] finish(input jtcm_pkg::div_out_t d);
    logic signed [jtcm_pkg::SQ_W-1:0] q;
    logic signed [jtcm_pkg::SQ_W-1:0] x;
    logic [W:0] r;
    q = jtcm_pkg::SQ_W'({1'b0, d.quot});
    x = d.neg ? -q : q;
    if (d.ovf) begin
      r = d.neg ? {1'b1, W'(jtcm_pkg::OUT_MIN)} : {1'b1, W'(jtcm_pkg::OUT_MAX)};
    end else begin
      r = clamp16((x + jtcm_pkg::SQ_W'(jtcm_pkg::ONE)) >>> 1);
    end
    return r;
  endfunction

  always_comb begin
    if (rational_mode) begin
      cx = finish(div_x);
      cy = finish(div_y);
    end else begin
      cx = clamp16(quad_x);
      cy = clamp16(quad_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item.tex_x     <= cx[W-1:0];
      item.tex_y     <= cy[W-1:0];
      item.saturated <= cx[W] | cy[W];
    end
  end

endmodule
